/* rtl/swg_pkg.sv */
// shared types and constants for the square-wave sweep generator
package swg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned STEP_W = 6;

  // iteration counts for the shared unit
  localparam logic [STEP_W-1:0] STEPS_WORD = 6'd32;
  localparam logic [STEP_W-1:0] STEPS_DUTY = 6'd7;

  localparam logic [WORD_W-1:0] DUTY_SCALE = 32'd100;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**23
  localparam logic [23:0]  RECIP_100   = 24'd10737419;
  localparam int unsigned  RECIP_SHIFT = 30;

  localparam logic [15:0] MAX_AMP_RST = 16'd1024;
  localparam logic [15:0] BIAS_RST    = 16'd2048;

  // configuration register indexes
  localparam logic REG_MAX_AMP = 1'b0;
  localparam logic REG_BIAS    = 1'b1;

  // item function codes
  localparam logic FUNC_NOTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [STEP_W-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] data;
  } push_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_PUSH = 4'b1000
  } seq_state_t;

  typedef enum logic [2:0] {
    JOB_PER = 3'b001,
    JOB_HI  = 3'b010,
    JOB_AMP = 3'b100
  } job_t;

endpackage

/* rtl/swg_alu.sv */
// shared bit-serial unit: shift-add multiply and restoring divide
module swg_alu (
  input  logic             clk,
  input  logic             rst,
  input  swg_pkg::alu_req_t req,
  output swg_pkg::alu_rsp_t rsp
);
  import swg_pkg::*;

  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] y;
  logic [STEP_W-1:0] cnt;
  alu_op_t           op;
  logic              running;
  logic              done;

  logic [WORD_W:0] shifted;
  logic [WORD_W:0] opnd_l;
  logic [WORD_W:0] opnd_r;
  logic            cin;
  logic [WORD_W:0] sum;

  // one adder serves both: acc + x for multiply, shifted - y for divide
  always_comb begin
    shifted = {acc, x[WORD_W-1]};
    if (op == ALU_DIV) begin
      opnd_l = shifted;
      opnd_r = ~{1'b0, y};
      cin    = 1'b1;
    end else begin
      opnd_l = {1'b0, acc};
      opnd_r = {1'b0, x};
      cin    = 1'b0;
    end
    sum = opnd_l + opnd_r + {{WORD_W{1'b0}}, cin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= req.steps - 6'd1;
      end else if (running) begin
        cnt <= cnt - 6'd1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      x   <= req.a;
      y   <= req.b;
      op  <= req.op;
    end else if (running) begin
      if (op == ALU_MUL) begin
        if (y[0]) begin
          acc <= sum[WORD_W-1:0];
        end
        x <= {x[WORD_W-2:0], 1'b0};
        y <= {1'b0, y[WORD_W-1:1]};
      end else begin
        // no borrow means the trial subtract fits
        if (!sum[WORD_W]) begin
          acc <= sum[WORD_W-1:0];
          x   <= {x[WORD_W-2:0], 1'b1};
        end else begin
          acc <= shifted[WORD_W-1:0];
          x   <= {x[WORD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = (op == ALU_DIV) ? x : acc;

endmodule

/* rtl/swg_seq.sv */
// tone state and the sequencer that drives the shared unit
module swg_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              func,
  input  logic [15:0]       start_period,
  input  logic [15:0]       end_period,
  input  logic [3:0]        octave,
  input  logic [6:0]        duty_percent,
  input  logic [15:0]       note_length,
  input  logic [15:0]       start_level,
  input  logic [15:0]       end_level,
  input  logic [15:0]       amp_limit,
  input  logic [15:0]       bias_level,
  output swg_pkg::push_t    push,
  input  logic              push_ready,
  output swg_pkg::alu_req_t alu_req,
  input  swg_pkg::alu_rsp_t alu_rsp
);
  import swg_pkg::*;

  seq_state_t state;
  job_t       job;
  logic       kick;
  logic       from_tick;

  logic [15:0] cur_start_period;
  logic [15:0] cur_end_period;
  logic [6:0]  cur_duty;
  logic [15:0] cur_length;
  logic [15:0] cur_start_amp;
  logic [15:0] cur_end_amp;
  logic [15:0] half_width;
  logic [15:0] cur_amp;
  logic        level_high;
  logic [15:0] phase_count;
  logic [31:0] progress;

  logic [15:0] p_reg;
  logic [31:0] mag;
  logic        neg;
  logic [15:0] sample_reg;

  logic        accept;
  logic [15:0] sp_sh;
  logic [15:0] ep_sh;
  logic [15:0] sa_cl;
  logic [15:0] ea_cl;
  logic [15:0] pc_inc;
  logic        half_edge;
  logic [15:0] sample_val;
  logic [15:0] len_div;
  logic [15:0] sweep_a;
  logic [15:0] sweep_b;
  logic [31:0] diff;
  logic [31:0] prod;
  logic [31:0] prod_mag;
  logic [15:0] quot16;
  logic [15:0] q16;
  logic [15:0] swept;
  logic [46:0] hi_scaled;
  logic [15:0] hi_q;
  logic [15:0] hw_new;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  always_comb begin
    sp_sh      = start_period >> octave;
    ep_sh      = end_period >> octave;
    sa_cl      = (start_level > amp_limit) ? amp_limit : start_level;
    ea_cl      = (end_level > amp_limit) ? amp_limit : end_level;
    pc_inc     = phase_count + 16'd1;
    half_edge  = (pc_inc >= half_width);
    sample_val = (level_high ? cur_amp : 16'd0) + bias_level - {1'b0, cur_amp[15:1]};
    len_div    = (cur_length == 16'd0) ? 16'd1 : cur_length;
    sweep_a    = (job == JOB_AMP) ? cur_start_amp : cur_start_period;
    sweep_b    = (job == JOB_AMP) ? cur_end_amp : cur_end_period;
    diff       = {16'd0, sweep_b} - {16'd0, sweep_a};
    prod       = alu_rsp.result;
    prod_mag   = prod[31] ? (~prod + 32'd1) : prod;
    quot16     = alu_rsp.result[15:0];
    // quotient sign restored here, division truncates toward zero
    q16        = neg ? (~quot16 + 16'd1) : quot16;
    swept      = sweep_a + q16;
    // period times duty stays below 2**23, so the reciprocal is exact
    hi_scaled  = 47'(prod[22:0]) * 47'(RECIP_100);
    hi_q       = hi_scaled[RECIP_SHIFT+15:RECIP_SHIFT];
    hw_new     = (!from_tick || level_high) ? hi_q : (p_reg - hi_q);
  end

  always_comb begin
    alu_req.start = kick;
    if (state == ST_DIV) begin
      alu_req.op    = ALU_DIV;
      alu_req.a     = mag;
      alu_req.b     = {16'd0, len_div};
      alu_req.steps = STEPS_WORD;
    end else if (job == JOB_HI) begin
      alu_req.op    = ALU_MUL;
      alu_req.a     = {16'd0, p_reg};
      alu_req.b     = {25'd0, cur_duty};
      alu_req.steps = STEPS_DUTY;
    end else begin
      alu_req.op    = ALU_MUL;
      alu_req.a     = diff;
      alu_req.b     = progress;
      alu_req.steps = STEPS_WORD;
    end
  end

  assign push.valid = (state == ST_PUSH);
  assign push.data  = sample_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      job              <= JOB_PER;
      kick             <= 1'b0;
      from_tick        <= 1'b0;
      cur_start_period <= '0;
      cur_end_period   <= '0;
      cur_duty         <= '0;
      cur_length       <= '0;
      cur_start_amp    <= '0;
      cur_end_amp      <= '0;
      half_width       <= '0;
      cur_amp          <= '0;
      level_high       <= 1'b0;
      phase_count      <= '0;
      progress         <= '0;
    end else begin
      kick <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (func == FUNC_NOTE) begin
              cur_start_period <= sp_sh;
              cur_end_period   <= ep_sh;
              cur_duty         <= duty_percent;
              cur_length       <= (note_length == 16'd0) ? 16'd1 : note_length;
              cur_start_amp    <= sa_cl;
              cur_end_amp      <= ea_cl;
              progress         <= '0;
              // a note that continues the last period keeps the running tone
              if (sp_sh != cur_end_period) begin
                cur_amp     <= sa_cl;
                level_high  <= ~level_high;
                phase_count <= '0;
                job         <= JOB_HI;
                from_tick   <= 1'b0;
                state       <= ST_MUL;
                kick        <= 1'b1;
              end
            end else begin
              progress <= progress + 32'd1;
              if (half_edge) begin
                phase_count <= '0;
                level_high  <= ~level_high;
                job         <= JOB_PER;
                from_tick   <= 1'b1;
                state       <= ST_MUL;
                kick        <= 1'b1;
              end else begin
                phase_count <= pc_inc;
                state       <= ST_PUSH;
              end
            end
          end
        end
        ST_MUL: begin
          if (alu_rsp.done) begin
            if (job == JOB_HI) begin
              // duty split needs only the multiply
              half_width <= hw_new;
              if (from_tick) begin
                job  <= JOB_AMP;
                kick <= 1'b1;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              state <= ST_DIV;
              kick  <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (alu_rsp.done) begin
            unique case (job)
              JOB_PER: begin
                job   <= JOB_HI;
                state <= ST_MUL;
                kick  <= 1'b1;
              end
              JOB_AMP: begin
                cur_amp <= swept;
                state   <= ST_PUSH;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg <= sample_val;
      if (func == FUNC_NOTE) begin
        p_reg <= sp_sh;
      end
    end
    if ((state == ST_MUL) && alu_rsp.done) begin
      mag <= prod_mag;
      neg <= prod[31];
    end
    if ((state == ST_DIV) && alu_rsp.done && (job == JOB_PER)) begin
      p_reg <= swept;
    end
  end

endmodule

/* rtl/square_wave_sweep_generator.sv */
// square-wave tone generator top level: config registers, output register
// A note beat (func 0) loads a new sweep and gives no sample; a tick beat
// (func 1) gives one sample, computed from the state as it stood when the
// beat was taken. A tick that does not reach a half-period edge goes
// straight to the output register; one that does runs the period sweep and
// the amplitude sweep as 32-step multiply/divide pairs and the duty split as
// a 7-step multiply, all on a single shift-add/subtract unit that resolves
// one bit per cycle. A note needs no arithmetic when its start period
// matches the previous end period, otherwise it runs the duty split. No new
// beat is taken until the current one is done. A finished sample waits in
// the output register without holding up the next beat; a tick whose sample
// finds that register still full waits until it drains.
module square_wave_sweep_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        func,
  input  logic [15:0] start_period,
  input  logic [15:0] end_period,
  input  logic [3:0]  octave,
  input  logic [6:0]  duty_percent,
  input  logic [15:0] note_length,
  input  logic [15:0] start_level,
  input  logic [15:0] end_level,
  output logic        sample_valid,
  input  logic        sample_ready,
  output logic [15:0] sample_out
);
  import swg_pkg::*;

  logic [15:0] amp_limit;
  logic [15:0] bias_level;
  push_t       push;
  logic        push_ready;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_limit  <= MAX_AMP_RST;
      bias_level <= BIAS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_AMP: amp_limit  <= cfg_data;
        REG_BIAS:    bias_level <= cfg_data;
        default:     amp_limit  <= amp_limit;
      endcase
    end
  end

  // output register frees the sequencer as soon as it is empty or draining
  assign push_ready = !sample_valid || sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (push.valid && push_ready) begin
      sample_valid <= 1'b1;
    end else if (sample_ready) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && push_ready) begin
      sample_out <= push.data;
    end
  end

  swg_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .start_period (start_period),
    .end_period   (end_period),
    .octave       (octave),
    .duty_percent (duty_percent),
    .note_length  (note_length),
    .start_level  (start_level),
    .end_level    (end_level),
    .amp_limit    (amp_limit),
    .bias_level   (bias_level),
    .push         (push),
    .push_ready   (push_ready),
    .alu_req      (alu_req),
    .alu_rsp      (alu_rsp)
  );

  swg_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

/* rtl/swg_checker.sv */
// port-level checks for the square-wave sweep generator, bound to the top level
module swg_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic        cfg_index,
  input logic [15:0] cfg_data,
  input logic        item_valid,
  input logic        item_ready,
  input logic        func,
  input logic [15:0] start_period,
  input logic [15:0] end_period,
  input logic [3:0]  octave,
  input logic [6:0]  duty_percent,
  input logic [15:0] note_length,
  input logic [15:0] start_level,
  input logic [15:0] end_level,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic [15:0] sample_out
);
  import swg_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid && $stable(sample_out))
    else $error("output beat changed while stalled");

  // after reset the block is idle with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> item_ready && !sample_valid)
    else $error("block not idle after reset");

  // the block is busy in the cycle after it takes a tick
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (func == FUNC_TICK) |=> !item_ready)
    else $error("input taken right after a tick");

  // a note never produces an output beat
  a_note_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (func == FUNC_NOTE) |=> !$rose(sample_valid))
    else $error("output beat after a note");

endmodule

bind square_wave_sweep_generator swg_port_checks u_swg_checker (.*);

/* verif/swg_checker.sv */
// checker for the square-wave sweep generator: predicts samples and compares them
module swg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        func,
  input  logic [15:0] start_period,
  input  logic [15:0] end_period,
  input  logic [3:0]  octave,
  input  logic [6:0]  duty_percent,
  input  logic [15:0] note_length,
  input  logic [15:0] start_level,
  input  logic [15:0] end_level,
  input  logic        sample_valid,
  input  logic        sample_ready,
  input  logic [15:0] sample_out,
  output int unsigned pending,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import swg_pkg::*;

  logic [15:0] max_amp = MAX_AMP_RST;
  logic [15:0] bias = BIAS_RST;

  logic [15:0] per_start;
  logic [15:0] per_end;
  logic [6:0]  duty;
  logic [31:0] sweep_len;
  logic [15:0] amp_start;
  logic [15:0] amp_end;
  logic [15:0] half_w;
  logic [15:0] amp_now;
  logic        lvl_high;
  logic [15:0] phase_cnt;
  logic [31:0] prog_cnt;

  logic [15:0] expected_samples[$];
  logic [15:0] want;
  int unsigned fails = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    fails++;
  endtask

  // a + ((b - a) * step) / span, 32-bit wrap, signed division toward zero
  function automatic logic [15:0] lin_sweep(input logic [31:0] a_val, input logic [31:0] b_val,
                                            input logic [31:0] step, input logic [31:0] span);
    logic [31:0] prod;
    longint      num;
    longint      den;
    prod = (b_val - a_val) * step;
    num  = longint'($signed(prod));
    den  = (span == 32'd0) ? 64'sd1 : longint'(span);
    return 16'(longint'(a_val) + num / den);
  endfunction

  function automatic logic [15:0] high_span(input logic [15:0] per, input logic [6:0] pct);
    logic [31:0] prod;
    prod = 32'(per) * 32'(pct);
    return 16'(prod / DUTY_SCALE);
  endfunction

  function automatic void load_note(input logic [15:0] sp, input logic [15:0] ep,
                                    input logic [3:0] oct, input logic [6:0] pct,
                                    input logic [15:0] len, input logic [15:0] sa,
                                    input logic [15:0] ea);
    logic [15:0] prev_end;
    prev_end  = per_end;
    per_start = sp >> oct;
    per_end   = ep >> oct;
    duty      = pct;
    sweep_len = (len != 16'd0) ? 32'(len) : 32'd1;
    amp_start = (sa > max_amp) ? max_amp : sa;
    amp_end   = (ea > max_amp) ? max_amp : ea;
    // a note that continues the previous end period keeps the running waveform
    if (per_start != prev_end) begin
      half_w    = high_span(per_start, duty);
      amp_now   = amp_start;
      lvl_high  = ~lvl_high;
      phase_cnt = '0;
    end
    prog_cnt = '0;
  endfunction

  function automatic logic [15:0] tick_sample();
    logic [15:0] smp;
    logic [15:0] per;
    logic [15:0] hi;
    smp = (lvl_high ? amp_now : 16'd0) + (bias - (amp_now >> 1));
    phase_cnt = phase_cnt + 16'd1;
    prog_cnt  = prog_cnt + 32'd1;
    if (phase_cnt >= half_w) begin
      phase_cnt = '0;
      lvl_high  = ~lvl_high;
      per       = lin_sweep(32'(per_start), 32'(per_end), prog_cnt, sweep_len);
      hi        = high_span(per, duty);
      half_w    = lvl_high ? hi : per - hi;
      amp_now   = lin_sweep(32'(amp_start), 32'(amp_end), prog_cnt, sweep_len);
    end
    return smp;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      max_amp   = MAX_AMP_RST;
      bias      = BIAS_RST;
      per_start = '0;
      per_end   = '0;
      duty      = '0;
      sweep_len = '0;
      amp_start = '0;
      amp_end   = '0;
      half_w    = '0;
      amp_now   = '0;
      lvl_high  = 1'b0;
      phase_cnt = '0;
      prog_cnt  = '0;
      expected_samples.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MAX_AMP) max_amp = cfg_data;
        else bias = cfg_data;
      end
      // output beat first, so it is never matched against this edge's input
      if (sample_valid && sample_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d with none pending", sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (sample_out !== want)
            report_mismatch($sformatf("sample_out %0d, predicted %0d", sample_out, want));
        end
      end
      if (item_valid && item_ready) begin
        if (func == FUNC_NOTE)
          load_note(start_period, end_period, octave, duty_percent, note_length,
                    start_level, end_level);
        else
          expected_samples.push_back(tick_sample());
      end
    end
    pending    <= expected_samples.size();
    fail_count <= fails;
  end

endmodule

/* verif/tb_top.sv */
// testbench top for the square-wave sweep generator: stimulus, pacing and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swg_pkg::*;

  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned IDLE_LIMIT   = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        func = 1'b0;
  logic [15:0] start_period = '0;
  logic [15:0] end_period = '0;
  logic [3:0]  octave = '0;
  logic [6:0]  duty_percent = '0;
  logic [15:0] note_length = '0;
  logic [15:0] start_level = '0;
  logic [15:0] end_level = '0;
  logic        sample_valid;
  logic        sample_ready = 1'b0;
  logic [15:0] sample_out;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [15:0] prev_end = '0;
  logic [15:0] ready_pat = 16'hFFFF;
  int unsigned pat_left = 0;

  always #5 clk = ~clk;

  square_wave_sweep_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .start_period (start_period),
    .end_period   (end_period),
    .octave       (octave),
    .duty_percent (duty_percent),
    .note_length  (note_length),
    .start_level  (start_level),
    .end_level    (end_level),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_out   (sample_out)
  );

  swg_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .start_period (start_period),
    .end_period   (end_period),
    .octave       (octave),
    .duty_percent (duty_percent),
    .note_length  (note_length),
    .start_level  (start_level),
    .end_level    (end_level),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_out   (sample_out),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  // receiver: rotating ready pattern, reloaded now and then, never all zero
  always @(posedge clk) begin
    if (pat_left == 0) begin
      ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      pat_left  <= $urandom_range(32, 300);
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
      pat_left  <= pat_left - 1;
    end
    sample_ready <= ready_pat[0];
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (sample_valid && sample_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_item(input logic f, input logic [15:0] sp, input logic [15:0] ep,
                           input logic [3:0] oct, input logic [6:0] pct,
                           input logic [15:0] len, input logic [15:0] sa,
                           input logic [15:0] ea);
    item_valid   <= 1'b1;
    func         <= f;
    start_period <= sp;
    end_period   <= ep;
    octave       <= oct;
    duty_percent <= pct;
    note_length  <= len;
    start_level  <= sa;
    end_level    <= ea;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    if (f == FUNC_NOTE) prev_end = ep >> oct;
    pace();
  endtask

  task automatic send_tick();
    send_item(FUNC_TICK, 16'($urandom), 16'($urandom), 4'($urandom), 7'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_note();
    logic [3:0]  oct;
    logic [15:0] sp;
    logic [15:0] ep;
    logic [6:0]  pct;
    logic [15:0] len;
    logic [15:0] sa;
    logic [15:0] ea;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    // mostly short shifted periods so half-period edges come often
    oct = 4'($urandom_range(0, 3));
    sp  = 16'(($urandom_range(0, 120) << oct) | ($urandom & ((1 << oct) - 1)));
    ep  = 16'(($urandom_range(0, 120) << oct) | ($urandom & ((1 << oct) - 1)));
    if (kind < 20) begin
      // continue from the last end period
      oct = (prev_end < 16'd2048) ? 4'($urandom_range(0, 5)) : 4'd0;
      sp  = 16'((prev_end << oct) | ($urandom & ((1 << oct) - 1)));
    end else if (kind < 35) begin
      oct = 4'($urandom_range(8, 15));
      sp  = 16'($urandom);
      ep  = 16'($urandom);
    end else if (kind < 45) begin
      oct = 4'($urandom);
      sp  = 16'($urandom);
      ep  = 16'($urandom);
    end
    pct = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(101, 127))
                                      : 7'($urandom_range(0, 100));
    len = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 64)) : 16'($urandom);
    sa  = $urandom_range(0, 1) ? 16'($urandom_range(0, 2048)) : 16'($urandom);
    ea  = $urandom_range(0, 1) ? 16'($urandom_range(0, 2048)) : 16'($urandom);
    send_item(FUNC_NOTE, sp, ep, oct, pct, len, sa, ea);
  endtask

  // stop sending, wait for every sample, then let a note finish its math
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase_end;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ticks before any note
    send_tick();
    send_tick();
    // zero periods match the reset end period, waveform kept
    send_item(FUNC_NOTE, 16'd0, 16'd0, 4'd0, 7'd50, 16'd0, 16'd0, 16'd0);
    send_tick();
    // full-scale fields, amplitudes clamped
    send_item(FUNC_NOTE, 16'hFFFF, 16'hFFFF, 4'd0, 7'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_tick();
    send_tick();
    // duty above hundred, zero length
    send_item(FUNC_NOTE, 16'd2, 16'd40, 4'd0, 7'd127, 16'd0, 16'd2000, 16'd0);
    repeat (3) send_tick();
    // largest octave, zero duty: an edge every tick, amplitude runs past its end level
    send_item(FUNC_NOTE, 16'hFFFF, 16'h8000, 4'd15, 7'd0, 16'd1, 16'd100, 16'd900);
    repeat (5) send_tick();
    // continues from the previous end period
    send_item(FUNC_NOTE, 16'd1, 16'd300, 4'd0, 7'd50, 16'd4, 16'd500, 16'd50);
    repeat (4) send_tick();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin write_reg(REG_MAX_AMP, 16'hFFFF); write_reg(REG_BIAS, 16'h0000); end
          2: begin write_reg(REG_MAX_AMP, 16'h0000); write_reg(REG_BIAS, 16'hFFFF); end
          4: begin
            write_reg(REG_MAX_AMP, 16'($urandom_range(1, 300)));
            write_reg(REG_BIAS, 16'h0000);
          end
          5: begin write_reg(REG_MAX_AMP, 16'hFFFF); write_reg(REG_BIAS, 16'hFFFF); end
          default: begin
            write_reg(REG_MAX_AMP, 16'($urandom));
            write_reg(REG_BIAS, 16'($urandom));
          end
        endcase
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: random functions and payloads
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
                      7'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          random_note();
          repeat ($urandom_range(1, 60)) send_tick();
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* square_wave_sweep_generator.f */
rtl/swg_pkg.sv
rtl/swg_alu.sv
rtl/swg_seq.sv
rtl/square_wave_sweep_generator.sv
rtl/swg_checker.sv
verif/swg_checker.sv
verif/tb_top.sv
